>>> src/motor_angle_command_framer_defines.svh
// Assertion macros for the motor angle command framer.
`ifndef MOTOR_ANGLE_COMMAND_FRAMER_DEFINES_SVH
`define MOTOR_ANGLE_COMMAND_FRAMER_DEFINES_SVH

`ifndef SYNTHESIS
`define MAF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("maf: same-cycle check failed");
`define MAF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("maf: next-cycle check failed");
`else
`define MAF_ASSERT_IMP(lbl, ante, cons)
`define MAF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> src/maf_pkg.sv
// Shared types, constants and the CRC step for the motor angle command framer.
package maf_pkg;

    typedef logic [31:0] t_counts;
    typedef logic [3:0]  t_byte_idx;

    typedef struct packed {
        logic      busy;
        t_byte_idx idx;
    } t_back_stat;

    localparam t_byte_idx IDX_HEAD   = 4'd0;
    localparam t_byte_idx IDX_RSVD   = 4'd1;
    localparam t_byte_idx IDX_ID     = 4'd2;
    localparam t_byte_idx IDX_CMD    = 4'd3;
    localparam t_byte_idx IDX_LEN    = 4'd4;
    localparam t_byte_idx IDX_CNT0   = 4'd5;
    localparam t_byte_idx IDX_CNT1   = 4'd6;
    localparam t_byte_idx IDX_CNT2   = 4'd7;
    localparam t_byte_idx IDX_CNT3   = 4'd8;
    localparam t_byte_idx IDX_CRC_LO = 4'd9;
    localparam t_byte_idx IDX_CRC_HI = 4'd10;

    localparam logic [7:0] HEAD_BYTE = 8'h3E;
    localparam logic [7:0] RSVD_BYTE = 8'h00;
    localparam logic [7:0] CMD_BYTE  = 8'h55;
    localparam logic [7:0] LEN_BYTE  = 8'h04;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic signed [24:0] HALF_TURN     = 25'sd46080;
    localparam logic signed [24:0] NEG_HALF_TURN = -25'sd46080;
    localparam logic signed [15:0] OFF_MIN       = -16'sd32768;
    localparam logic signed [15:0] OFF_MAX       = 16'sd32767;

    // floor(x / 45) = (x * RECIP_45) >> RECIP_SHIFT for 0 <= x < 2^29
    localparam logic [28:0] DIV_BIAS    = 29'd377487360;
    localparam logic [29:0] RECIP_45    = 30'd763549742;
    localparam int          RECIP_SHIFT = 35;
    localparam logic [5:0]  DIVISOR     = 6'd45;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> src/maf_if.sv
// Channel interfaces: input ticks, output frame bytes, configuration writes.
interface maf_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] target_angle;
    logic               stop;
    modport source (output valid, output target_angle, output stop, input ready);
    modport sink (input valid, input target_angle, input stop, output ready);
endinterface

interface maf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_of_frame;
    modport source (output valid, output frame_byte, output last_of_frame, input ready);
    modport sink (input valid, input frame_byte, input last_of_frame, output ready);
endinterface

interface maf_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] motor_index;
    modport source (output valid, output motor_index, input ready);
    modport sink (input valid, input motor_index, output ready);
endinterface

>>> src/maf_front.sv
// Front pipeline: accept ticks, unwrap turns, convert to encoder counts.
module maf_front import maf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    maf_in_if.sink  i_in,
    output logic    o_valid,
    input  logic    i_ready,
    output t_counts o_counts
);

    logic               en;
    logic               accept;
    logic signed [24:0] w_diff;
    logic signed [15:0] n_off;
    logic [29:0]        w_sum;
    logic [23:0]        w_q;
    logic [5:0]         w_q45;
    logic [5:0]         w_rem;
    logic [31:0]        w_floor32;
    logic [31:0]        w_off_counts;
    logic [31:0]        w_base;
    logic [31:0]        n_counts;

    logic signed [23:0] r_prev;
    logic signed [15:0] r_off;

    logic               r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic signed [23:0] r_s1_t;
    logic               r_s1_stop, r_s2_stop, r_s3_stop;
    logic signed [15:0] r_s1_off, r_s2_off;
    logic [58:0]        r_s2_prod;
    logic [5:0]         r_s2_xlo;
    logic [31:0]        r_s3_base;
    logic [31:0]        r_s3_offc;
    logic               r_s3_fix;
    t_counts            r_s4_counts;

    assign en         = !r_s4_v || i_ready;
    assign i_in.ready = en;
    assign accept     = i_in.valid && en;

    assign w_diff = $signed({i_in.target_angle[23], i_in.target_angle}) -
                    $signed({r_prev[23], r_prev});

    always_comb begin
        n_off = r_off;
        if (w_diff > HALF_TURN && r_off != OFF_MIN) begin
            n_off = r_off - 16'sd1;
        end else if (w_diff < NEG_HALF_TURN && r_off != OFF_MAX) begin
            n_off = r_off + 16'sd1;
        end
    end

    assign w_sum = {{3{r_s1_t[23]}}, r_s1_t, 3'b000} + {1'b0, DIV_BIAS};

    assign w_q          = r_s2_prod[58:RECIP_SHIFT];
    assign w_q45        = w_q[5:0] * DIVISOR;
    assign w_rem        = r_s2_xlo - w_q45;
    assign w_floor32    = {{8{~w_q[23]}}, ~w_q[23], w_q[22:0]};
    assign w_off_counts = {{2{r_s2_off[15]}}, r_s2_off, 14'b0};

    assign w_base   = w_floor32 + w_off_counts;
    assign n_counts = r_s3_stop ? r_s3_offc : (r_s3_base + {31'b0, r_s3_base[31] & r_s3_fix});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_off  <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            if (accept) begin
                r_prev <= i_in.target_angle;
                r_off  <= n_off;
            end
            if (en) begin
                r_s1_v <= accept;
                r_s2_v <= r_s1_v;
                r_s3_v <= r_s2_v;
                r_s4_v <= r_s3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_t      <= i_in.target_angle;
            r_s1_stop   <= i_in.stop;
            r_s1_off    <= n_off;
            r_s2_prod   <= 59'(w_sum[28:0]) * 59'(RECIP_45);
            r_s2_xlo    <= w_sum[5:0];
            r_s2_stop   <= r_s1_stop;
            r_s2_off    <= r_s1_off;
            r_s3_base   <= w_base;
            r_s3_offc   <= w_off_counts;
            r_s3_fix    <= (w_rem != 6'd0);
            r_s3_stop   <= r_s2_stop;
            r_s4_counts <= n_counts;
        end
    end

    assign o_valid  = r_s4_v;
    assign o_counts = r_s4_counts;

endmodule

>>> src/maf_queue.sv
// Two-entry queue of encoder counts between front and back.
module maf_queue import maf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_counts i_counts,
    output logic    o_valid,
    input  logic    i_ready,
    output t_counts o_counts
);

    logic    push, pop;
    logic    r_head_v, r_tail_v;
    t_counts r_head, r_tail;

    assign o_ready = !r_tail_v;
    assign push    = i_valid && !r_tail_v;
    assign pop     = r_head_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_tail_v <= 1'b0;
        end else begin
            if (pop) begin
                if (r_tail_v) begin
                    r_tail_v <= 1'b0;
                end else begin
                    r_head_v <= push;
                end
            end else if (push) begin
                if (r_head_v) begin
                    r_tail_v <= 1'b1;
                end else begin
                    r_head_v <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_tail_v) begin
                r_head <= r_tail;
            end else if (push) begin
                r_head <= i_counts;
            end
        end else if (push) begin
            if (r_head_v) begin
                r_tail <= i_counts;
            end else begin
                r_head <= i_counts;
            end
        end
    end

    assign o_valid  = r_head_v;
    assign o_counts = r_head;

endmodule

>>> src/maf_back.sv
// Back end: serialize one command frame per count value, with running CRC.
module maf_back import maf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_motor_index,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_counts    i_counts,
    maf_out_if.source  o_out,
    output t_back_stat o_stat
);

    logic        advance;
    logic        at_last;
    logic        load;
    logic [7:0]  w_byte;

    logic        r_busy;
    t_byte_idx   r_idx;
    t_counts     r_cnt;
    logic [15:0] r_crc;
    logic        r_out_v;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    assign advance = r_busy && (!r_out_v || o_out.ready);
    assign at_last = (r_idx == IDX_CRC_HI);
    assign o_ready = !r_busy || (advance && at_last);
    assign load    = i_valid && o_ready;

    always_comb begin
        unique case (r_idx)
            IDX_HEAD:   w_byte = HEAD_BYTE;
            IDX_RSVD:   w_byte = RSVD_BYTE;
            IDX_ID:     w_byte = i_motor_index + 8'd1;
            IDX_CMD:    w_byte = CMD_BYTE;
            IDX_LEN:    w_byte = LEN_BYTE;
            IDX_CNT0:   w_byte = r_cnt[7:0];
            IDX_CNT1:   w_byte = r_cnt[15:8];
            IDX_CNT2:   w_byte = r_cnt[23:16];
            IDX_CNT3:   w_byte = r_cnt[31:24];
            IDX_CRC_LO: w_byte = r_crc[7:0];
            IDX_CRC_HI: w_byte = r_crc[15:8];
            default:    w_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= IDX_HEAD;
            r_out_v <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= IDX_HEAD;
            end else if (advance && at_last) begin
                r_busy <= 1'b0;
                r_idx  <= IDX_HEAD;
            end else if (advance) begin
                r_idx <= r_idx + 4'd1;
            end
            if (advance) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cnt <= i_counts;
            r_crc <= CRC_INIT;
        end else if (advance && r_idx <= IDX_CNT3) begin
            r_crc <= crc_byte(r_crc, w_byte);
        end
        if (advance) begin
            r_out_byte <= w_byte;
            r_out_last <= at_last;
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.frame_byte    = r_out_byte;
    assign o_out.last_of_frame = r_out_last;

    assign o_stat.busy = r_busy;
    assign o_stat.idx  = r_idx;

endmodule

>>> src/motor_angle_command_framer.sv
// Top level of the motor angle command framer.
//
//   channel  | dir | payload                         | item
//   i_in     | in  | target_angle[23:0] s, stop      | one control tick
//   o_out    | out | frame_byte[7:0], last_of_frame  | one frame byte
//   i_cfg    | in  | motor_index[7:0]                | one register write
//
// Each tick yields 11 bytes, one per cycle while o_out is ready.
// The first byte passes through the 4 front stages, the queue, the frame load and the
// output register.
// Front and back stall independently through a two-entry queue of count values.
// Reset is synchronous, active low; it clears the unwrap state, motor index and all valids.
// i_cfg is always ready.
`include "motor_angle_command_framer_defines.svh"

module motor_angle_command_framer import maf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    maf_in_if.sink    i_in,
    maf_out_if.source o_out,
    maf_cfg_if.sink   i_cfg
);

    logic       f_valid, f_ready;
    t_counts    f_counts;
    logic       q_valid, q_ready;
    t_counts    q_counts;
    t_back_stat b_stat;
    logic [7:0] r_motor_index;
    logic       last_taken;

    assign i_cfg.ready = 1'b1;
    assign last_taken  = o_out.valid && o_out.ready && o_out.last_of_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_index <= '0;
        end else if (i_cfg.valid) begin
            r_motor_index <= i_cfg.motor_index;
        end
    end

    maf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_valid  (f_valid),
        .i_ready  (f_ready),
        .o_counts (f_counts)
    );

    maf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (f_valid),
        .o_ready  (f_ready),
        .i_counts (f_counts),
        .o_valid  (q_valid),
        .i_ready  (q_ready),
        .o_counts (q_counts)
    );

    maf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_motor_index (r_motor_index),
        .i_valid       (q_valid),
        .o_ready       (q_ready),
        .i_counts      (q_counts),
        .o_out         (o_out),
        .o_stat        (b_stat)
    );

    `MAF_ASSERT_IMP(a_idle_idx_home, !b_stat.busy, b_stat.idx == IDX_HEAD)
    `MAF_ASSERT_NEXT(a_head_after_last, last_taken, !o_out.valid || o_out.frame_byte == HEAD_BYTE)
    `MAF_ASSERT_IMP(a_last_only_at_crc, o_out.valid && o_out.last_of_frame, b_stat.busy || b_stat.idx == IDX_HEAD)

endmodule
